// ----- src/md5bh_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// md5bh_pkg
// Shared types, constants and round functions for the MD5 block hash core.
// ----------------------------------------------------------------------------
package md5bh_pkg;

  localparam int WORD_W = 32;

  localparam logic [WORD_W-1:0] IV_A = 32'h67452301;
  localparam logic [WORD_W-1:0] IV_B = 32'hefcdab89;
  localparam logic [WORD_W-1:0] IV_C = 32'h98badcfe;
  localparam logic [WORD_W-1:0] IV_D = 32'h10325476;

  // one full block handed from the front end to the round engine
  typedef struct packed {
    logic bank;
    logic start;
    logic msg_end;
  } blk_desc_t;

  // write port into the two-bank block buffer
  typedef struct packed {
    logic              en;
    logic [4:0]        addr;
    logic [WORD_W-1:0] data;
  } buf_wr_t;

  function automatic logic [WORD_W-1:0] round_k(input logic [5:0] r);
    logic [WORD_W-1:0] k;
    case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] round_s(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
      4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
      4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
      4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  4'hf: s = 5'd21;
      default: s = 5'd7;
    endcase
    return s;
  endfunction

  // message word index for a round; all arithmetic is mod 16
  function automatic logic [3:0] round_w(input logic [5:0] r);
    logic [3:0] r4;
    logic [3:0] w;
    r4 = r[3:0];
    case (r[5:4])
      2'd0:    w = r4;
      2'd1:    w = 4'((r4 << 2) + r4 + 4'd1);
      2'd2:    w = 4'((r4 << 1) + r4 + 4'd5);
      default: w = 4'((r4 << 3) - r4);
    endcase
    return w;
  endfunction

  function automatic logic [WORD_W-1:0] round_f(input logic [1:0] q,
                                                input logic [WORD_W-1:0] b,
                                                input logic [WORD_W-1:0] c,
                                                input logic [WORD_W-1:0] d);
    logic [WORD_W-1:0] f;
    case (q)
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (b & d) | (c & ~d);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

  function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] x,
                                               input logic [4:0] s);
    logic [2*WORD_W-1:0] t;
    t = {x, x} << s;
    return t[2*WORD_W-1:WORD_W];
  endfunction

endpackage
`default_nettype wire

// ----- src/md5bh_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// md5bh_if
// Valid/ready channels: message words in, digest words out.
// ----------------------------------------------------------------------------
interface md5bh_in_if;
  import md5bh_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] message_word;
  logic              message_start;
  logic              message_end;

  modport source (output valid, output message_word, output message_start,
                  output message_end, input ready);
  modport sink   (input valid, input message_word, input message_start,
                  input message_end, output ready);
endinterface

interface md5bh_out_if;
  import md5bh_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] digest_word;
  logic [1:0]        digest_index;
  logic              digest_last;

  modport source (output valid, output digest_word, output digest_index,
                  output digest_last, input ready);
  modport sink   (input valid, input digest_word, input digest_index,
                  input digest_last, output ready);
endinterface
`default_nettype wire

// ----- src/md5bh_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// md5bh_front
// Word collector: places words into the free buffer bank, tracks the block
// position and start flag, and queues a descriptor per completed block.
// ----------------------------------------------------------------------------
module md5bh_front (
  input  wire                    clk,
  input  wire                    rst_n,
  md5bh_in_if.sink               in_chan,
  output md5bh_pkg::buf_wr_t     buf_wr,
  output logic                   push_valid,
  output md5bh_pkg::blk_desc_t   push_desc,
  input  wire                    release_blk
);
  import md5bh_pkg::*;

  logic [3:0] pos_r, pos_nxt;
  logic       bank_r, bank_nxt;
  logic       blk_start_r, blk_start_nxt;
  logic [1:0] busy_r, busy_nxt;   // banks held by queued or running blocks

  logic       acc;
  logic [3:0] pos_eff;

  assign in_chan.ready = ~busy_r[1];
  assign acc           = in_chan.valid & in_chan.ready;
  // start restarts the block: word goes to slot 0, partial block dropped
  assign pos_eff       = in_chan.message_start ? 4'd0 : pos_r;

  always_comb begin
    buf_wr.en   = acc;
    buf_wr.addr = {bank_r, pos_eff};
    buf_wr.data = in_chan.message_word;

    push_valid        = acc & (pos_eff == 4'd15);
    push_desc.bank    = bank_r;
    push_desc.start   = blk_start_r;
    push_desc.msg_end = in_chan.message_end;

    pos_nxt       = acc ? 4'(pos_eff + 4'd1) : pos_r;
    bank_nxt      = push_valid ? ~bank_r : bank_r;
    blk_start_nxt = blk_start_r;
    if (acc) begin
      if (in_chan.message_start) begin
        blk_start_nxt = 1'b1;
      end else if (push_valid) begin
        blk_start_nxt = 1'b0;
      end
    end

    case ({push_valid, release_blk})
      2'b10:   busy_nxt = 2'(busy_r + 2'd1);
      2'b01:   busy_nxt = 2'(busy_r - 2'd1);
      default: busy_nxt = busy_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      bank_r      <= 1'b0;
      blk_start_r <= 1'b0;
      busy_r      <= '0;
    end else begin
      pos_r       <= pos_nxt;
      bank_r      <= bank_nxt;
      blk_start_r <= blk_start_nxt;
      busy_r      <= busy_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- src/md5bh_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// md5bh_queue
// Two-entry descriptor queue between the word collector and the round engine.
// ----------------------------------------------------------------------------
module md5bh_queue (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    push,
  input  md5bh_pkg::blk_desc_t   push_desc,
  input  wire                    pop,
  output logic                   not_empty,
  output md5bh_pkg::blk_desc_t   pop_desc
);
  import md5bh_pkg::*;

  blk_desc_t  slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign not_empty = (cnt_r != 2'd0);
  assign pop_desc  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    case ({push, pop})
      2'b10:   cnt_nxt = 2'(cnt_r + 2'd1);
      2'b01:   cnt_nxt = 2'(cnt_r - 2'd1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_desc;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- src/md5bh_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// md5bh_back
// Round engine: two-bank block buffer, one MD5 round per cycle, chaining
// words, and the digest output sequencer.
// ----------------------------------------------------------------------------
module md5bh_back (
  input  wire                    clk,
  input  wire                    rst_n,
  input  md5bh_pkg::buf_wr_t     buf_wr,
  input  wire                    q_valid,
  input  md5bh_pkg::blk_desc_t   q_desc,
  output logic                   q_pop,
  output logic                   release_blk,
  md5bh_out_if.source            out_chan
);
  import md5bh_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_ADD, ST_OUT} state_t;

  state_t            state_r, state_nxt;
  logic [5:0]        round_r, round_nxt;
  logic [WORD_W-1:0] a_r, b_r, c_r, d_r;
  logic [WORD_W-1:0] a_nxt, b_nxt, c_nxt, d_nxt;
  logic [WORD_W-1:0] chain_r [4];
  logic [WORD_W-1:0] chain_nxt [4];
  logic              bank_r, bank_nxt;
  logic              end_r, end_nxt;
  logic [1:0]        idx_r, idx_nxt;

  logic [WORD_W-1:0] mem [32];
  logic [WORD_W-1:0] rd_data_r;
  logic [4:0]        rd_addr;

  logic [WORD_W-1:0] sum;
  logic [WORD_W-1:0] b_round;

  // prefetch the message word of the next round
  assign rd_addr = (state_r == ST_IDLE) ? {q_desc.bank, 4'd0}
                                        : {bank_r, round_w(6'(round_r + 6'd1))};

  always_ff @(posedge clk) begin
    if (buf_wr.en) begin
      mem[buf_wr.addr] <= buf_wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign sum     = a_r + round_f(round_r[5:4], b_r, c_r, d_r) + round_k(round_r)
                   + rd_data_r;
  assign b_round = b_r + rotl32(sum, round_s(round_r));

  assign out_chan.valid        = (state_r == ST_OUT);
  assign out_chan.digest_word  = chain_r[idx_r];
  assign out_chan.digest_index = idx_r;
  assign out_chan.digest_last  = (idx_r == 2'd3);

  always_comb begin
    state_nxt = state_r;
    round_nxt = round_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    c_nxt     = c_r;
    d_nxt     = d_r;
    for (int i = 0; i < 4; i++) begin
      chain_nxt[i] = chain_r[i];
    end
    bank_nxt    = bank_r;
    end_nxt     = end_r;
    idx_nxt     = idx_r;
    q_pop       = 1'b0;
    release_blk = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          bank_nxt  = q_desc.bank;
          end_nxt   = q_desc.msg_end;
          round_nxt = '0;
          state_nxt = ST_RUN;
          if (q_desc.start) begin
            chain_nxt[0] = IV_A;
            chain_nxt[1] = IV_B;
            chain_nxt[2] = IV_C;
            chain_nxt[3] = IV_D;
            a_nxt = IV_A;
            b_nxt = IV_B;
            c_nxt = IV_C;
            d_nxt = IV_D;
          end else begin
            a_nxt = chain_r[0];
            b_nxt = chain_r[1];
            c_nxt = chain_r[2];
            d_nxt = chain_r[3];
          end
        end
      end
      ST_RUN: begin
        a_nxt     = d_r;
        b_nxt     = b_round;
        c_nxt     = b_r;
        d_nxt     = c_r;
        round_nxt = 6'(round_r + 6'd1);
        if (round_r == 6'd63) begin
          release_blk = 1'b1;   // last buffer read is done, bank is free
          state_nxt   = ST_ADD;
        end
      end
      ST_ADD: begin
        chain_nxt[0] = chain_r[0] + a_r;
        chain_nxt[1] = chain_r[1] + b_r;
        chain_nxt[2] = chain_r[2] + c_r;
        chain_nxt[3] = chain_r[3] + d_r;
        idx_nxt      = '0;
        state_nxt    = end_r ? ST_OUT : ST_IDLE;
      end
      ST_OUT: begin
        if (out_chan.ready) begin
          if (idx_r == 2'd3) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = 2'(idx_r + 2'd1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    round_r <= round_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    c_r     <= c_nxt;
    d_r     <= d_nxt;
    bank_r  <= bank_nxt;
    end_r   <= end_nxt;
    idx_r   <= idx_nxt;
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      chain_r[0] <= IV_A;
      chain_r[1] <= IV_B;
      chain_r[2] <= IV_C;
      chain_r[3] <= IV_D;
    end else begin
      state_r <= state_nxt;
      for (int i = 0; i < 4; i++) begin
        chain_r[i] <= chain_nxt[i];
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/md5_block_hash_core.sv -----
`default_nettype none
// From the word 15 transfer the descriptor is queued, the idle engine pops it,
//   runs the rounds, adds into the chaining words and presents the digest,
//   then one digest word per cycle while out_chan is ready. Blocks run one MD5
//   round per cycle; two banks fill ahead.
// Reset: chaining words load the MD5 initial values, word position and queue
//   clear; buffer contents are undefined until written.
// ----------------------------------------------------------------------------
// md5_block_hash_core
// MD5 compression of a pre-padded message, 32-bit little-endian words in,
// four digest words out after a block flagged as the message end.
// ----------------------------------------------------------------------------
module md5_block_hash_core (
  input  wire          clk,
  input  wire          rst_n,
  md5bh_in_if.sink     in_chan,
  md5bh_out_if.source  out_chan
);
  import md5bh_pkg::*;

  buf_wr_t   buf_wr;
  logic      push_valid;
  blk_desc_t push_desc;
  logic      release_blk;
  logic      q_pop;
  logic      q_valid;
  blk_desc_t q_desc;

  md5bh_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .buf_wr      (buf_wr),
    .push_valid  (push_valid),
    .push_desc   (push_desc),
    .release_blk (release_blk)
  );

  md5bh_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_desc (push_desc),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_desc  (q_desc)
  );

  md5bh_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .buf_wr      (buf_wr),
    .q_valid     (q_valid),
    .q_desc      (q_desc),
    .q_pop       (q_pop),
    .release_blk (release_blk),
    .out_chan    (out_chan)
  );

endmodule
`default_nettype wire

// ----- verif/md5_block_hash_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// md5_block_hash_core_tb
// Streams padded message words into the MD5 core with random gaps on both
// channels. A scoreboard runs its own MD5 compression on each completed
// block of transferred words and checks the digest words in order.
// ----------------------------------------------------------------------------
module md5_block_hash_core_tb;
  import md5bh_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 9;
  localparam int STALL_LIMIT   = 3000;
  localparam int HOLD_CYCLES   = 500;
  localparam int DRAIN_CYCLES  = 100;
  localparam int RANDOM_WORDS  = 160;
  localparam int PRESSURE_MSGS = 5;
  localparam int MAX_PRINTED   = 40;

  localparam logic [1:0] LAST_INDEX = 2'd3;
  localparam logic [3:0] LAST_SLOT  = 4'd15;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [1:0]        index;
    logic              last;
  } digest_word_t;

  class md5_digest_scoreboard;
    logic [WORD_W-1:0] chain [4];
    logic [WORD_W-1:0] blk [16];
    logic [WORD_W-1:0] sine_k [64];
    int                shift_amt [16];
    logic [3:0]        slot;
    digest_word_t      digests_due [$];
    int                digests_predicted;
    int                mismatches;

    function new();
      real    s;
      longint k;
      // round constants straight from their definition: floor(2^32 * |sin(i+1)|)
      for (int i = 0; i < 64; i++) begin
        s = $sin(i + 1.0);
        if (s < 0.0) s = -s;
        k = longint'($floor(s * 4294967296.0));
        sine_k[i] = k[31:0];
      end
      shift_amt = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
      load_iv();
      slot = '0;
      digests_predicted = 0;
      mismatches = 0;
    endfunction

    function void load_iv();
      chain[0] = IV_A;
      chain[1] = IV_B;
      chain[2] = IV_C;
      chain[3] = IV_D;
    endfunction

    function void run_rounds();
      logic [WORD_W-1:0] a, b, c, d, f, sum, rot, held;
      int q, w, sh;
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      for (int r = 0; r < 64; r++) begin
        q = r / 16;
        case (q)
          0: begin
            f = (b & c) | (~b & d);
            w = r;
          end
          1: begin
            f = (b & d) | (c & ~d);
            w = (5 * r + 1) % 16;
          end
          2: begin
            f = b ^ c ^ d;
            w = (3 * r + 5) % 16;
          end
          default: begin
            f = c ^ (b | ~d);
            w = (7 * r) % 16;
          end
        endcase
        sum  = a + f + sine_k[r] + blk[w];
        sh   = shift_amt[q * 4 + r % 4];
        rot  = (sum << sh) | (sum >> (32 - sh));
        held = d;
        d    = c;
        c    = b;
        b    = b + rot;
        a    = held;
      end
      chain[0] = chain[0] + a;
      chain[1] = chain[1] + b;
      chain[2] = chain[2] + c;
      chain[3] = chain[3] + d;
    endfunction

    // one input transfer: store the word, compress on the last slot
    function void note_word(input logic [WORD_W-1:0] w, input logic s, input logic e);
      digest_word_t dw;
      if (s) begin
        load_iv();
        slot = '0;
      end
      blk[slot] = w;
      if (slot == LAST_SLOT) begin
        run_rounds();
        if (e) begin
          for (int i = 0; i < 4; i++) begin
            dw.word  = chain[i];
            dw.index = 2'(i);
            dw.last  = (2'(i) == LAST_INDEX);
            digests_due.push_back(dw);
          end
          digests_predicted++;
        end
      end
      slot = slot + 4'd1;
    endfunction

    function void report(input string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED)
        $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    function void check_digest(input logic [WORD_W-1:0] word, input logic [1:0] index,
                               input logic last);
      digest_word_t want;
      if (digests_due.size() == 0) begin
        report($sformatf("unexpected digest word %h index %0d", word, index));
        return;
      end
      want = digests_due.pop_front();
      if (word !== want.word)
        report($sformatf("digest_word %h, want %h (index %0d)", word, want.word, want.index));
      if (index !== want.index)
        report($sformatf("digest_index %0d, want %0d", index, want.index));
      if (last !== want.last)
        report($sformatf("digest_last %b, want %b (index %0d)", last, want.last, want.index));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  md5bh_in_if  in_chan_if ();
  md5bh_out_if out_chan_if ();

  md5_block_hash_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan_if),
    .out_chan (out_chan_if)
  );

  md5_digest_scoreboard sb;
  bit calm_src;
  bit calm_sink;
  bit hold_req;
  int words_sent;
  int idle_cycles = 0;

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  function automatic logic [WORD_W-1:0] rand_word();
    logic [WORD_W-1:0] w;
    case ($urandom_range(0, 9))
      0:       w = '0;
      1:       w = '1;
      2:       w = 32'h1 << $urandom_range(0, 31);
      3:       w = ~(32'h1 << $urandom_range(0, 31));
      default: w = $urandom;
    endcase
    return w;
  endfunction

  task automatic send_word(input logic [WORD_W-1:0] w, input logic s, input logic e);
    int gap;
    gap = calm_src ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_chan_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan_if.valid         <= 1'b1;
    in_chan_if.message_word  <= w;
    in_chan_if.message_start <= s;
    in_chan_if.message_end   <= e;
    do @(posedge clk); while (!in_chan_if.ready);
    sb.note_word(w, s, e);
    words_sent++;
  endtask

  // padded message of whole blocks; cut leaves it unfinished
  task automatic send_message(input int nblocks, input bit with_start, input bit with_end,
                              input bit cut);
    int   total;
    int   stop;
    logic e;
    total = 16 * nblocks;
    stop  = cut ? $urandom_range(1, total - 1) : total;
    for (int i = 0; i < stop; i++) begin
      if (i == total - 1)
        e = with_end;
      else if (i % 16 == 15)
        e = 1'b0;
      else
        e = ($urandom_range(0, 15) == 0);
      send_word(rand_word(), with_start && (i == 0), e);
    end
  endtask

  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++)
      send_word(rand_word(), $urandom_range(0, 7) == 0, $urandom_range(0, 3) == 0);
  endtask

  // output monitor and stall watchdog
  always @(posedge clk) begin
    if (rst_n && out_chan_if.valid && out_chan_if.ready)
      sb.check_digest(out_chan_if.digest_word, out_chan_if.digest_index,
                      out_chan_if.digest_last);
    if (!rst_n || (in_chan_if.valid && in_chan_if.ready) ||
        (out_chan_if.valid && out_chan_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("md5_block_hash_core verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : digest_sink
    int gap;
    out_chan_if.ready <= 1'b0;
    calm_sink = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      // long hold-off so the core backs up and stalls the word channel
      if (hold_req) begin
        hold_req = 1'b0;
        out_chan_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = calm_sink ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
        out_chan_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_chan_if.ready <= 1'b1;
      do @(posedge clk); while (!out_chan_if.valid);
      if ($urandom_range(0, 11) == 0) calm_sink = !calm_sink;
    end
  end

  initial begin : word_source
    logic [WORD_W-1:0] w;
    int msg;
    sb = new();
    rst_n                    <= 1'b0;
    in_chan_if.valid         <= 1'b0;
    in_chan_if.message_word  <= '0;
    in_chan_if.message_start <= 1'b0;
    in_chan_if.message_end   <= 1'b0;
    calm_src   = 1'b0;
    hold_req   = 1'b0;
    words_sent = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: stray end, restart mid-block with start and end together,
    // then a full block of edge words ending in a digest
    send_word(32'h0000_0000, 1'b1, 1'b0);
    send_word(32'hffff_ffff, 1'b0, 1'b1);
    send_word(32'h1234_5678, 1'b0, 1'b0);
    send_word(32'hffff_ffff, 1'b1, 1'b1);
    for (int i = 1; i < 15; i++) begin
      case (i % 4)
        0:       w = '0;
        1:       w = '1;
        2:       w = 32'h1 << i;
        default: w = ~(32'h1 << i);
      endcase
      send_word(w, 1'b0, 1'b0);
    end
    send_word(32'h8000_0001, 1'b0, 1'b1);
    // carry on after the digest without a start flag
    for (int i = 0; i < 6; i++)
      send_word($urandom, 1'b0, i[0]);

    hold_req   = 1'b1;
    msg        = 0;
    while (words_sent < RANDOM_WORDS) begin
      if (msg < PRESSURE_MSGS) begin
        calm_src = 1'b1;
        send_message(1, 1'b1, 1'b1, 1'b0);
      end else begin
        calm_src = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 7) == 0)
          send_noise($urandom_range(1, 20));
        else
          send_message($urandom_range(1, 3), $urandom_range(0, 5) != 0,
                       $urandom_range(0, 7) != 0, $urandom_range(0, 9) == 0);
      end
      msg++;
    end
    in_chan_if.valid <= 1'b0;

    while (sb.digests_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0)
      $display("md5_block_hash_core verification clean");
    else
      $display("md5_block_hash_core verification failed");
    $finish;
  end

endmodule

// ----- files.f -----
src/md5bh_pkg.sv
src/md5bh_if.sv
src/md5bh_front.sv
src/md5bh_queue.sv
src/md5bh_back.sv
src/md5_block_hash_core.sv
verif/md5_block_hash_core_tb.sv
